// ===== design/fsp_pkg.sv =====
// shared types and constants of the strip packer
`timescale 1ns / 1ps
package fsp_pkg;

  localparam int MAX_RECTS = 32;
  localparam int SIZE_BITS = 24;
  localparam int IDX_W     = $clog2(MAX_RECTS);
  localparam int CNT_W     = $clog2(MAX_RECTS + 1);
  localparam int BASE_W    = 29;
  localparam int FILL_W    = 29;
  localparam int SHELF_W   = 5;
  localparam int ID_W      = 6;
  localparam int STAT_W    = 2;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_UNDO   = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
  } rect_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] shelf;
  } ord_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] tall;
    logic [FILL_W-1:0]    fill;
    logic [BASE_W-1:0]    base;
  } shelf_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [SHELF_W-1:0]   shelf;
    logic [BASE_W-1:0]    bottom;
    logic [ID_W-1:0]      id;
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
    logic                 last;
  } res_t;

endpackage

// ===== design/fsp_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module fsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/fsp_out_reg.sv =====
// result output register between sequencer and result channel
`timescale 1ns / 1ps
module fsp_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  fsp_pkg::res_t din,
  input  logic          out_ready,
  output logic          free,
  output logic          out_valid,
  output fsp_pkg::res_t dout
);
  import fsp_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

  assign out_valid = valid_r;
  assign dout      = data_r;

endmodule

// ===== design/ffdh_strip_packer.sv =====
// first-fit-decreasing-height strip packer, top level and sequencer
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+----------------------
//  input   | in_command, in_rect_width, in_rect_height | in_valid & in_ready
//  result  | out_status .. out_last (7 fields)         | out_valid & out_ready
//  config  | cfg_wdata (strip width)                   | cfg_we
//
// one command at a time; rectangles, list order and shelves sit in three rams with one read port each
// insert: walk the list down from the tail, moving entries up until a taller one ends it
// undo: scan the list for the newest slot and close the gap behind it
// report: place each rectangle on the first shelf that fits it, then for each shelf
//   scan the list and emit the rectangles on that shelf
// reset clears the rectangle count, returns to idle and sets the strip width to 65536; rams need no clearing pass
// a stalled result holds the sequencer; the next command is taken once idle
`timescale 1ns / 1ps
module ffdh_strip_packer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  logic [fsp_pkg::SIZE_BITS-1:0] in_rect_width,
  input  logic [fsp_pkg::SIZE_BITS-1:0] in_rect_height,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fsp_pkg::STAT_W-1:0]    out_status,
  output logic [fsp_pkg::SHELF_W-1:0]   out_shelf_index,
  output logic [fsp_pkg::BASE_W-1:0]    out_shelf_bottom,
  output logic [fsp_pkg::ID_W-1:0]      out_rect_id,
  output logic [fsp_pkg::SIZE_BITS-1:0] out_width,
  output logic [fsp_pkg::SIZE_BITS-1:0] out_height,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [fsp_pkg::SIZE_BITS-1:0] cfg_wdata
);
  import fsp_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_EMIT   = 18'h00002,
    INS_RD   = 18'h00004,
    INS_SLOT = 18'h00008,
    INS_CMP  = 18'h00010,
    UND_RD   = 18'h00020,
    UND_CHK  = 18'h00040,
    UND_FIN  = 18'h00080,
    R1_ORD   = 18'h00100,
    R1_RECT  = 18'h00200,
    R1_GET   = 18'h00400,
    R1_SCAN  = 18'h00800,
    R1_CHK   = 18'h01000,
    R2_SHELF = 18'h02000,
    R2_BASE  = 18'h04000,
    R2_ORD   = 18'h08000,
    R2_CHK   = 18'h10000,
    R2_RECT  = 18'h20000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt;
  logic [CNT_W-1:0]     s_r, s_nxt;
  logic [CNT_W-1:0]     shelves_r, shelves_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic                 found_r, found_nxt;
  logic                 rep_r, rep_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [SIZE_BITS-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [BASE_W-1:0]    base_sum_r, base_sum_nxt;
  logic [BASE_W-1:0]    bottom_r, bottom_nxt;
  logic [SIZE_BITS-1:0] strip_r;
  res_t                 res_r, res_nxt;

  logic             rect_we, rect_re, ord_we, ord_re, shf_we, shf_re;
  logic [IDX_W-1:0] rect_wa, rect_ra, ord_wa, ord_ra, shf_wa, shf_ra;
  rect_t            rect_wd, rect_rd;
  ord_t             ord_wd, ord_rd;
  shelf_t           shf_wd, shf_rd;

  logic             out_free, out_load;
  res_t             out_data;

  logic [FILL_W:0]  fill_sum;
  logic             fits;
  logic [IDX_W-1:0] newest_slot;

  assign fill_sum    = {1'b0, shf_rd.fill} + (FILL_W+1)'(w_r);
  assign fits        = (shf_rd.tall >= h_r) && (fill_sum <= (FILL_W+1)'(strip_r));
  assign newest_slot = IDX_W'(cnt_r - CNT_W'(1));
  assign in_ready    = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    i_nxt        = i_r;
    s_nxt        = s_r;
    shelves_nxt  = shelves_r;
    k_nxt        = k_r;
    found_nxt    = found_r;
    rep_nxt      = rep_r;
    slot_nxt     = slot_r;
    w_nxt        = w_r;
    h_nxt        = h_r;
    base_sum_nxt = base_sum_r;
    bottom_nxt   = bottom_r;
    res_nxt      = res_r;
    rect_we = 1'b0; rect_wa = '0; rect_wd = '0;
    rect_re = 1'b0; rect_ra = '0;
    ord_we  = 1'b0; ord_wa  = '0; ord_wd  = '0;
    ord_re  = 1'b0; ord_ra  = '0;
    shf_we  = 1'b0; shf_wa  = '0; shf_wd  = '0;
    shf_re  = 1'b0; shf_ra  = '0;
    out_load = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rep_nxt = 1'b0;
          res_nxt = '0;
          res_nxt.last = 1'b1;
          unique case (cmd_t'(in_command))
            CMD_INSERT: begin
              if (cnt_r == CNT_W'(MAX_RECTS)) begin
                res_nxt.status = ST_FULL;
                state_nxt = S_EMIT;
              end else begin
                rect_we = 1'b1;
                rect_wa = IDX_W'(cnt_r);
                rect_wd = '{w: in_rect_width, h: in_rect_height};
                w_nxt = in_rect_width;
                h_nxt = in_rect_height;
                i_nxt = cnt_r;
                state_nxt = INS_RD;
              end
            end
            CMD_UNDO: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                i_nxt = '0;
                found_nxt = 1'b0;
                state_nxt = UND_RD;
              end
            end
            CMD_REPORT: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                i_nxt = '0;
                shelves_nxt = '0;
                base_sum_nxt = '0;
                k_nxt = '0;
                state_nxt = R1_ORD;
              end
            end
            CMD_NONE: begin
              state_nxt = S_IDLE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // walk down from the tail, moving entries up until a taller one shows
      INS_RD: begin
        if (i_r == '0) begin
          ord_we = 1'b1;
          ord_wa = '0;
          ord_wd = '{slot: IDX_W'(cnt_r), shelf: '0};
          res_nxt = '{status: ST_OK, shelf: '0, bottom: '0,
                      id: ID_W'(cnt_r) + ID_W'(1), w: w_r, h: h_r, last: 1'b1};
          cnt_nxt = cnt_r + CNT_W'(1);
          state_nxt = S_EMIT;
        end else begin
          ord_re = 1'b1;
          ord_ra = IDX_W'(i_r - CNT_W'(1));
          state_nxt = INS_SLOT;
        end
      end
      INS_SLOT: begin
        slot_nxt = ord_rd.slot;
        rect_re = 1'b1;
        rect_ra = ord_rd.slot;
        state_nxt = INS_CMP;
      end
      INS_CMP: begin
        ord_we = 1'b1;
        ord_wa = IDX_W'(i_r);
        if (rect_rd.h > h_r) begin
          ord_wd = '{slot: IDX_W'(cnt_r), shelf: '0};
          res_nxt = '{status: ST_OK, shelf: '0, bottom: '0,
                      id: ID_W'(cnt_r) + ID_W'(1), w: w_r, h: h_r, last: 1'b1};
          cnt_nxt = cnt_r + CNT_W'(1);
          state_nxt = S_EMIT;
        end else begin
          ord_wd = '{slot: slot_r, shelf: '0};
          i_nxt = i_r - CNT_W'(1);
          state_nxt = INS_RD;
        end
      end

      // find the newest slot in the list and close the gap behind it
      UND_RD: begin
        if (i_r == cnt_r) begin
          rect_re = 1'b1;
          rect_ra = newest_slot;
          state_nxt = UND_FIN;
        end else begin
          ord_re = 1'b1;
          ord_ra = IDX_W'(i_r);
          state_nxt = UND_CHK;
        end
      end
      UND_CHK: begin
        if (found_r) begin
          ord_we = 1'b1;
          ord_wa = IDX_W'(i_r - CNT_W'(1));
          ord_wd = ord_rd;
        end
        if (ord_rd.slot == newest_slot) begin
          found_nxt = 1'b1;
        end
        i_nxt = i_r + CNT_W'(1);
        state_nxt = UND_RD;
      end
      UND_FIN: begin
        res_nxt = '{status: ST_OK, shelf: '0, bottom: '0, id: ID_W'(cnt_r),
                    w: rect_rd.w, h: rect_rd.h, last: 1'b1};
        cnt_nxt = cnt_r - CNT_W'(1);
        state_nxt = S_EMIT;
      end

      // first pass: place every rectangle on a shelf
      R1_ORD: begin
        if (i_r == cnt_r) begin
          s_nxt = '0;
          state_nxt = R2_SHELF;
        end else begin
          ord_re = 1'b1;
          ord_ra = IDX_W'(i_r);
          state_nxt = R1_RECT;
        end
      end
      R1_RECT: begin
        slot_nxt = ord_rd.slot;
        rect_re = 1'b1;
        rect_ra = ord_rd.slot;
        state_nxt = R1_GET;
      end
      R1_GET: begin
        w_nxt = rect_rd.w;
        h_nxt = rect_rd.h;
        s_nxt = '0;
        if (shelves_r == '0) begin
          shf_we = 1'b1;
          shf_wa = IDX_W'(shelves_r);
          shf_wd = '{tall: rect_rd.h, fill: FILL_W'(rect_rd.w), base: base_sum_r};
          ord_we = 1'b1;
          ord_wa = IDX_W'(i_r);
          ord_wd = '{slot: slot_r, shelf: IDX_W'(shelves_r)};
          base_sum_nxt = base_sum_r + BASE_W'(rect_rd.h);
          shelves_nxt = shelves_r + CNT_W'(1);
          i_nxt = i_r + CNT_W'(1);
          state_nxt = R1_ORD;
        end else begin
          state_nxt = R1_SCAN;
        end
      end
      R1_SCAN: begin
        shf_re = 1'b1;
        shf_ra = IDX_W'(s_r);
        state_nxt = R1_CHK;
      end
      R1_CHK: begin
        if (fits) begin
          shf_we = 1'b1;
          shf_wa = IDX_W'(s_r);
          shf_wd = '{tall: shf_rd.tall, fill: FILL_W'(fill_sum), base: shf_rd.base};
          ord_we = 1'b1;
          ord_wa = IDX_W'(i_r);
          ord_wd = '{slot: slot_r, shelf: IDX_W'(s_r)};
          i_nxt = i_r + CNT_W'(1);
          state_nxt = R1_ORD;
        end else if (s_r + CNT_W'(1) == shelves_r) begin
          // no shelf takes it: open one on top of the stack
          shf_we = 1'b1;
          shf_wa = IDX_W'(shelves_r);
          shf_wd = '{tall: h_r, fill: FILL_W'(w_r), base: base_sum_r};
          ord_we = 1'b1;
          ord_wa = IDX_W'(i_r);
          ord_wd = '{slot: slot_r, shelf: IDX_W'(shelves_r)};
          base_sum_nxt = base_sum_r + BASE_W'(h_r);
          shelves_nxt = shelves_r + CNT_W'(1);
          i_nxt = i_r + CNT_W'(1);
          state_nxt = R1_ORD;
        end else begin
          s_nxt = s_r + CNT_W'(1);
          state_nxt = R1_SCAN;
        end
      end

      // second pass: list the rectangles shelf by shelf
      R2_SHELF: begin
        if (s_r == shelves_r) begin
          state_nxt = S_IDLE;
        end else begin
          shf_re = 1'b1;
          shf_ra = IDX_W'(s_r);
          i_nxt = '0;
          state_nxt = R2_BASE;
        end
      end
      R2_BASE: begin
        bottom_nxt = shf_rd.base;
        state_nxt = R2_ORD;
      end
      R2_ORD: begin
        if (i_r == cnt_r) begin
          s_nxt = s_r + CNT_W'(1);
          state_nxt = R2_SHELF;
        end else begin
          ord_re = 1'b1;
          ord_ra = IDX_W'(i_r);
          state_nxt = R2_CHK;
        end
      end
      R2_CHK: begin
        if (ord_rd.shelf == IDX_W'(s_r)) begin
          slot_nxt = ord_rd.slot;
          rect_re = 1'b1;
          rect_ra = ord_rd.slot;
          state_nxt = R2_RECT;
        end else begin
          i_nxt = i_r + CNT_W'(1);
          state_nxt = R2_ORD;
        end
      end
      R2_RECT: begin
        res_nxt = '{status: ST_OK, shelf: SHELF_W'(s_r), bottom: bottom_r,
                    id: ID_W'(slot_r) + ID_W'(1), w: rect_rd.w, h: rect_rd.h,
                    last: (k_r + CNT_W'(1) == cnt_r)};
        k_nxt = k_r + CNT_W'(1);
        rep_nxt = 1'b1;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (rep_r && !res_r.last) begin
            i_nxt = i_r + CNT_W'(1);
            state_nxt = R2_ORD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      strip_r <= SIZE_BITS'(65536);
      rep_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rep_r   <= rep_nxt;
      found_r <= found_nxt;
      if (cfg_we) begin
        strip_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    s_r        <= s_nxt;
    shelves_r  <= shelves_nxt;
    k_r        <= k_nxt;
    slot_r     <= slot_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    base_sum_r <= base_sum_nxt;
    bottom_r   <= bottom_nxt;
    res_r      <= res_nxt;
  end

  fsp_ram #(.WIDTH($bits(rect_t)), .DEPTH(MAX_RECTS)) u_rect_ram (
    .clk(clk), .we(rect_we), .waddr(rect_wa), .wdata(rect_wd),
    .re(rect_re), .raddr(rect_ra), .rdata(rect_rd)
  );

  fsp_ram #(.WIDTH($bits(ord_t)), .DEPTH(MAX_RECTS)) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
    .re(ord_re), .raddr(ord_ra), .rdata(ord_rd)
  );

  fsp_ram #(.WIDTH($bits(shelf_t)), .DEPTH(MAX_RECTS)) u_shelf_ram (
    .clk(clk), .we(shf_we), .waddr(shf_wa), .wdata(shf_wd),
    .re(shf_re), .raddr(shf_ra), .rdata(shf_rd)
  );

  fsp_out_reg u_out_reg (
    .clk(clk), .rst_n(rst_n), .load(out_load), .din(res_r),
    .out_ready(out_ready), .free(out_free), .out_valid(out_valid), .dout(out_data)
  );

  assign out_status       = out_data.status;
  assign out_shelf_index  = out_data.shelf;
  assign out_shelf_bottom = out_data.bottom;
  assign out_rect_id      = out_data.id;
  assign out_width        = out_data.w;
  assign out_height       = out_data.h;
  assign out_last         = out_data.last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RECTS))
    else $error("rectangle count above store depth");

  a_shelves_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == R1_CHK || state_r == R2_ORD) |-> shelves_r <= cnt_r)
    else $error("more shelves than rectangles");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> out_valid)
    else $error("result not presented after emit");

  a_ram_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(shf_we && shf_re && shf_wa == shf_ra))
    else $error("shelf ram read and write collide");

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the first-fit-decreasing-height strip packer
`timescale 1ns / 1ps
module tb;
  import fsp_pkg::*;

  localparam int LIMIT_CYCLES = 5000000;
  localparam int SETTLE_CYCLES = 6000;

  typedef struct {
    cmd_t                 cmd;
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
    bit                   fixed;
    res_t                 res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_command = CMD_NONE;
  logic [SIZE_BITS-1:0] in_rect_width = '0;
  logic [SIZE_BITS-1:0] in_rect_height = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [SHELF_W-1:0]   out_shelf_index;
  logic [BASE_W-1:0]    out_shelf_bottom;
  logic [ID_W-1:0]      out_rect_id;
  logic [SIZE_BITS-1:0] out_width;
  logic [SIZE_BITS-1:0] out_height;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [SIZE_BITS-1:0] cfg_wdata = '0;

  ffdh_strip_packer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_rect_width(in_rect_width), .in_rect_height(in_rect_height),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_shelf_index(out_shelf_index), .out_shelf_bottom(out_shelf_bottom),
    .out_rect_id(out_rect_id), .out_width(out_width), .out_height(out_height),
    .out_last(out_last), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // packer mirror
  logic [SIZE_BITS-1:0] strip_w;
  logic [SIZE_BITS-1:0] rect_w [MAX_RECTS];
  logic [SIZE_BITS-1:0] rect_h [MAX_RECTS];
  int                   by_height [MAX_RECTS];
  int                   n_rects;
  res_t                 pending_res[$];
  int                   n_errors = 0;
  int                   n_results = 0;
  int                   cycles = 0;

  task automatic push_res(logic [1:0] st, int shelf, logic [63:0] bottom, int id,
                          logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h, bit last);
    res_t r;
    r.status = st;
    r.shelf  = shelf[SHELF_W-1:0];
    r.bottom = bottom[BASE_W-1:0];
    r.id     = id[ID_W-1:0];
    r.w      = w;
    r.h      = h;
    r.last   = last;
    pending_res.insert(pending_res.size(), r);
  endtask

  task automatic pack_shelves();
    logic [63:0] tall [MAX_RECTS];
    logic [63:0] fill [MAX_RECTS];
    logic [63:0] base [MAX_RECTS];
    logic [63:0] sum;
    int          on_shelf [MAX_RECTS];
    int          n_shelves;
    int          slot;
    int          k;
    bit          placed;
    n_shelves = 0;
    for (int p = 0; p < n_rects; p++) begin
      slot = by_height[p];
      placed = 0;
      for (int s = 0; s < n_shelves; s++) begin
        if (!placed && tall[s] >= rect_h[slot] && fill[s] + rect_w[slot] <= strip_w) begin
          fill[s] += rect_w[slot];
          on_shelf[p] = s;
          placed = 1;
        end
      end
      if (!placed) begin
        sum = 0;
        for (int s = 0; s < n_shelves; s++) sum += tall[s];
        base[n_shelves] = sum;
        tall[n_shelves] = rect_h[slot];
        fill[n_shelves] = rect_w[slot];
        on_shelf[p] = n_shelves;
        n_shelves++;
      end
    end
    k = 0;
    for (int s = 0; s < n_shelves; s++)
      for (int p = 0; p < n_rects; p++)
        if (on_shelf[p] == s) begin
          slot = by_height[p];
          k++;
          push_res(ST_OK, s, base[s], slot + 1, rect_w[slot], rect_h[slot], k == n_rects);
        end
  endtask

  task automatic predict_packer(cmd_t cmd, logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h);
    int pos;
    int slot;
    case (cmd)
      CMD_INSERT: begin
        if (n_rects >= MAX_RECTS) begin
          push_res(ST_FULL, 0, 0, 0, 0, 0, 1);
        end else begin
          rect_w[n_rects] = w;
          rect_h[n_rects] = h;
          pos = 0;
          while (pos < n_rects && rect_h[by_height[pos]] > h) pos++;
          for (int i = n_rects; i > pos; i--) by_height[i] = by_height[i-1];
          by_height[pos] = n_rects;
          n_rects++;
          push_res(ST_OK, 0, 0, n_rects, w, h, 1);
        end
      end
      CMD_UNDO: begin
        if (n_rects == 0) begin
          push_res(ST_EMPTY, 0, 0, 0, 0, 0, 1);
        end else begin
          slot = n_rects - 1;
          pos = 0;
          while (pos < n_rects && by_height[pos] != slot) pos++;
          for (int i = pos; i + 1 < n_rects; i++) by_height[i] = by_height[i+1];
          n_rects--;
          push_res(ST_OK, 0, 0, slot + 1, rect_w[slot], rect_h[slot], 1);
        end
      end
      CMD_REPORT: begin
        if (n_rects == 0) push_res(ST_EMPTY, 0, 0, 0, 0, 0, 1);
        else pack_shelves();
      end
      default: ;
    endcase
  endtask

  // result side: random stalls, one long hold-off to back up the input
  int out_gap = 0;
  int out_burst = 0;
  always @(posedge clk) begin
    res_t e;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_res.size() == 0) begin
          $display("%0t: unexpected result status=%0d id=%0d", $time, out_status, out_rect_id);
          n_errors++;
        end else begin
          e = pending_res.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
            n_errors++;
          end
          if (out_shelf_index !== e.shelf) begin
            $display("%0t: shelf_index exp %0d got %0d", $time, e.shelf, out_shelf_index);
            n_errors++;
          end
          if (out_shelf_bottom !== e.bottom) begin
            $display("%0t: shelf_bottom exp %h got %h", $time, e.bottom, out_shelf_bottom);
            n_errors++;
          end
          if (out_rect_id !== e.id) begin
            $display("%0t: rect_id exp %0d got %0d", $time, e.id, out_rect_id);
            n_errors++;
          end
          if (out_width !== e.w) begin
            $display("%0t: width exp %h got %h", $time, e.w, out_width);
            n_errors++;
          end
          if (out_height !== e.h) begin
            $display("%0t: height exp %h got %h", $time, e.h, out_height);
            n_errors++;
          end
          if (out_last !== e.last) begin
            $display("%0t: last exp %0d got %0d", $time, e.last, out_last);
            n_errors++;
          end
        end
        if (n_results == 40) out_gap = 400;
        else if (out_burst > 0) begin
          out_burst--;
          out_gap = 0;
        end else begin
          if ($urandom_range(0, 9) == 0) out_burst = 25;
          out_gap = $urandom_range(0, 13);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  int in_burst = 0;

  task automatic send_cmd(cmd_t cmd, logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h);
    int gap;
    if (in_burst > 0) begin
      in_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 9) == 0) in_burst = 15;
      gap = $urandom_range(0, 13);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_rect_width  <= w;
    in_rect_height <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_packer(cmd, w, h);
  endtask

  // hold the sender until every result is in, let a stray command settle, then write the strip width
  task automatic set_strip(logic [SIZE_BITS-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    strip_w = v;
  endtask

  function automatic logic [SIZE_BITS-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 24'($urandom_range(0, 24'hFFFFFF));
      1: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
      default: return 24'($urandom_range(1, 8)) << 13;
    endcase
  endfunction

  function automatic cmd_t pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return CMD_INSERT;
    if (r < 72) return CMD_UNDO;
    if (r < 95) return CMD_REPORT;
    return CMD_NONE;
  endfunction

  dir_row_t dir_rows[12];

  initial begin
    res_t none;
    none = '0;
    dir_rows = '{
      '{CMD_UNDO,   24'h0, 24'h0, 1'b1, '{ST_EMPTY, 5'd0, 29'd0, 6'd0, 24'h0, 24'h0, 1'b1}},
      '{CMD_REPORT, 24'h0, 24'h0, 1'b1, '{ST_EMPTY, 5'd0, 29'd0, 6'd0, 24'h0, 24'h0, 1'b1}},
      '{CMD_NONE,   24'hFFFFFF, 24'hFFFFFF, 1'b0, none},
      '{CMD_INSERT, 24'hFFFFFF, 24'hFFFFFF, 1'b1,
        '{ST_OK, 5'd0, 29'd0, 6'd1, 24'hFFFFFF, 24'hFFFFFF, 1'b1}},
      '{CMD_INSERT, 24'h0, 24'h0, 1'b1, '{ST_OK, 5'd0, 29'd0, 6'd2, 24'h0, 24'h0, 1'b1}},
      '{CMD_INSERT, 24'h8000, 24'h10000, 1'b1,
        '{ST_OK, 5'd0, 29'd0, 6'd3, 24'h8000, 24'h10000, 1'b1}},
      // equal height: the later insert goes ahead in the list
      '{CMD_INSERT, 24'h8000, 24'h10000, 1'b1,
        '{ST_OK, 5'd0, 29'd0, 6'd4, 24'h8000, 24'h10000, 1'b1}},
      '{CMD_INSERT, 24'h4000, 24'h8000, 1'b1,
        '{ST_OK, 5'd0, 29'd0, 6'd5, 24'h4000, 24'h8000, 1'b1}},
      '{CMD_REPORT, 24'h0, 24'h0, 1'b0, none},
      '{CMD_UNDO,   24'h0, 24'h0, 1'b1, '{ST_OK, 5'd0, 29'd0, 6'd5, 24'h4000, 24'h8000, 1'b1}},
      '{CMD_REPORT, 24'h0, 24'h0, 1'b0, none},
      '{CMD_NONE,   24'h0, 24'h0, 1'b0, none}
    };
    strip_w = 24'd65536;
    n_rects = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, dir_rows[i].w, dir_rows[i].h);
      if (dir_rows[i].fixed) begin
        pending_res[pending_res.size() - 1] = dir_rows[i].res;
      end
    end

    // fill past full, pack a full store, then drain past empty
    set_strip(24'hFFFFFF);
    repeat (MAX_RECTS + 2) send_cmd(CMD_INSERT, pick_size(), pick_size());
    send_cmd(CMD_REPORT, 24'h0, 24'h0);
    repeat (MAX_RECTS + 1) send_cmd(CMD_UNDO, pick_size(), pick_size());
    send_cmd(CMD_REPORT, 24'h0, 24'h0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_strip(24'h0);
        1: set_strip(24'($urandom_range(24'h8000, 24'h30000)));
        2: set_strip(24'($urandom_range(0, 24'hFFFFFF)));
        default: set_strip(24'd65536);
      endcase
      repeat (20) send_cmd(pick_cmd(), pick_size(), pick_size());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fsp_pkg.sv
design/fsp_ram.sv
design/fsp_out_reg.sv
design/ffdh_strip_packer.sv
bench/tb.sv
